FILE: design/sktd_pkg.sv
// Shared constants for the 6k+/-1 trial-division prime tester.
package sktd_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;

endpackage

FILE: design/sktd_serial_div.sv
// Restoring divider that develops one quotient bit per cycle.
module sktd_serial_div import sktd_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [VALUE_BITS-1:0] remainder
);

   localparam int CntBits = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [VALUE_BITS-1:0] den_ff, den_in;
   logic [VALUE_BITS:0]   shifted;
   logic                  fits;

   assign shifted = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntBits'(VALUE_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = VALUE_BITS'(shifted - {1'b0, den_ff});
         end else begin
            rem_in = shifted[VALUE_BITS-1:0];
         end
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         cnt_in = cnt_ff - CntBits'(1);
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

FILE: design/six_k_trial_division_prime_test.sv
// Top level of the 6k+/-1 trial-division prime tester.
//
// Request channel: req_valid / req_stall carry one signed candidate of
// VALUE_BITS bits. Response channel: rsp_valid / rsp_stall carry is_prime,
// one response per request, in order.
// Negative values, 0 and 1 give 0; 2 and 3 give 1; even values give 0 at once.
// Other values are divided by 3 and then by d and d+2 for d = 5, 11, 17, ...
// while d <= n / d, in a serial divider. At most 2 * k + 2 divisions are done,
// k being the number of d values with d <= n / d; the early cases above are
// answered without a division.
// One request is worked at a time; req_stall is high from acceptance until
// the response is loaded into the output register.
// If the receiver stalls, the response holds in the output register; the
// next request is still taken and computed, and its result waits until the
// output register frees.
// Reset clears the sequencer and drops any request in flight or response
// not yet taken.
module six_k_trial_division_prime_test import sktd_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_candidate,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_prime
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV3 = 3'd1;
   localparam logic [2:0] S_DIVA = 3'd2;
   localparam logic [2:0] S_DIVB = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic                  result_ff, result_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_is_prime_ff, rsp_is_prime_in;

   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [VALUE_BITS-1:0] div_divisor;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [VALUE_BITS-1:0] div_remainder;
   logic                  out_free;

   sktd_serial_div #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      result_in    = result_ff;
      div_start    = 1'b0;
      div_dividend = n_ff;
      div_divisor  = d_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               n_in     = req_candidate;
               state_in = S_DONE;
               if (req_candidate[VALUE_BITS-1] || req_candidate <= VALUE_BITS'(1)) begin
                  result_in = 1'b0;
               end else if (req_candidate <= VALUE_BITS'(3)) begin
                  result_in = 1'b1;
               end else if (!req_candidate[0]) begin
                  result_in = 1'b0;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = req_candidate;
                  div_divisor  = VALUE_BITS'(3);
                  state_in     = S_DIV3;
               end
            end
         end
         S_DIV3: begin
            if (div_done) begin
               if (div_remainder == '0) begin
                  result_in = 1'b0;
                  state_in  = S_DONE;
               end else begin
                  d_in        = VALUE_BITS'(5);
                  div_start   = 1'b1;
                  div_divisor = VALUE_BITS'(5);
                  state_in    = S_DIVA;
               end
            end
         end
         S_DIVA: begin
            if (div_done) begin
               if (d_ff > div_quotient) begin
                  result_in = 1'b1;
                  state_in  = S_DONE;
               end else if (div_remainder == '0) begin
                  result_in = 1'b0;
                  state_in  = S_DONE;
               end else begin
                  div_start   = 1'b1;
                  div_divisor = d_ff + VALUE_BITS'(2);
                  state_in    = S_DIVB;
               end
            end
         end
         S_DIVB: begin
            if (div_done) begin
               if (div_remainder == '0) begin
                  result_in = 1'b0;
                  state_in  = S_DONE;
               end else begin
                  d_in        = d_ff + VALUE_BITS'(6);
                  div_start   = 1'b1;
                  div_divisor = d_ff + VALUE_BITS'(6);
                  state_in    = S_DIVA;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_is_prime_in = rsp_is_prime_ff;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in    = 1'b1;
         rsp_is_prime_in = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff            <= n_in;
      d_ff            <= d_in;
      result_ff       <= result_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV3 || state_ff == S_DIVA || state_ff == S_DIVB))
      else $error("divider finished outside a divide state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != S_IDLE)
      else $error("accepted request did not leave idle");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response loaded outside done state");

   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVA || state_ff == S_DIVB) |-> d_ff[0])
      else $error("trial divisor is even");

endmodule
